### rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants for the label region statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  localparam int LABELS     = 256;
  localparam int LABEL_BITS = $clog2(LABELS);
  localparam int COORD_BITS = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int AREA_W     = 25;
  localparam int SUM_W      = 36;

  localparam logic [AREA_W-1:0] AREA_MAX = AREA_W'(25'd16777216);
  localparam logic [SUM_W-1:0]  SUM_MAX  = SUM_W'(36'd68702699520);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } lrs_kind_e;

  typedef struct packed {
    logic [AREA_W-1:0]     area;
    logic [SUM_W-1:0]      sum_x;
    logic [SUM_W-1:0]      sum_y;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_y;
  } lrs_entry_t;

  localparam int ENTRY_W = $bits(lrs_entry_t);

  typedef struct packed {
    logic [AREA_W-1:0]     area;
    logic [SUM_W-1:0]      sum_x;
    logic [SUM_W-1:0]      sum_y;
    logic [CFG_W-1:0]      min_x;
    logic [COORD_BITS-1:0] max_x;
    logic [CFG_W-1:0]      min_y;
    logic [COORD_BITS-1:0] max_y;
  } lrs_result_t;

  typedef struct packed {
    logic mem_we;
    logic set_used;
    logic clear_all;
    logic res_vld;
  } lrs_ctl_t;

endpackage

`default_nettype wire

### rtl/lrs_ram.sv
// ----------------------------------------------------------------------------
// lrs_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/lrs_merge.sv
// ----------------------------------------------------------------------------
// lrs_merge
// Folds one pixel into a label entry, and forms the answer to a query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrs_merge
  import lrs_pkg::*;
(
  input  wire logic [1:0]            kind_i,
  input  wire logic [COORD_BITS-1:0] pos_x_i,
  input  wire logic [COORD_BITS-1:0] pos_y_i,
  input  wire logic                  label_ok_i,
  input  wire logic                  used_i,
  input  wire lrs_entry_t            entry_i,
  input  wire logic [CFG_W-1:0]      image_width_i,
  input  wire logic [CFG_W-1:0]      image_height_i,
  output lrs_entry_t                 entry_o,
  output lrs_ctl_t                   ctl_o,
  output lrs_result_t                result_o
);

  logic [AREA_W:0]           area_sum;
  logic [SUM_W:0]            sx_sum;
  logic [SUM_W:0]            sy_sum;
  logic [CFG_W-1:0]          px_ext;
  logic [CFG_W-1:0]          py_ext;
  lrs_entry_t                upd;
  lrs_entry_t                first;

  always_comb begin
    px_ext   = CFG_W'(pos_x_i);
    py_ext   = CFG_W'(pos_y_i);
    area_sum = (AREA_W+1)'(entry_i.area) + (AREA_W+1)'(1'b1);
    sx_sum   = (SUM_W+1)'(entry_i.sum_x) + (SUM_W+1)'(pos_x_i);
    sy_sum   = (SUM_W+1)'(entry_i.sum_y) + (SUM_W+1)'(pos_y_i);

    upd.area  = (area_sum > (AREA_W+1)'(AREA_MAX)) ? AREA_MAX : area_sum[AREA_W-1:0];
    upd.sum_x = (sx_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sx_sum[SUM_W-1:0];
    upd.sum_y = (sy_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sy_sum[SUM_W-1:0];
    upd.min_x = (pos_x_i < entry_i.min_x) ? pos_x_i : entry_i.min_x;
    upd.max_x = (pos_x_i > entry_i.max_x) ? pos_x_i : entry_i.max_x;
    upd.min_y = (pos_y_i < entry_i.min_y) ? pos_y_i : entry_i.min_y;
    upd.max_y = (pos_y_i > entry_i.max_y) ? pos_y_i : entry_i.max_y;

    // first pixel of a label; the min never exceeds the pixel, so 12 bits hold it
    first.area  = AREA_W'(1'b1);
    first.sum_x = SUM_W'(pos_x_i);
    first.sum_y = SUM_W'(pos_y_i);
    first.min_x = (px_ext < image_width_i) ? pos_x_i : image_width_i[COORD_BITS-1:0];
    first.max_x = pos_x_i;
    first.min_y = (py_ext < image_height_i) ? pos_y_i : image_height_i[COORD_BITS-1:0];
    first.max_y = pos_y_i;

    entry_o = used_i ? upd : first;

    if (label_ok_i && used_i) begin
      result_o.area  = entry_i.area;
      result_o.sum_x = entry_i.sum_x;
      result_o.sum_y = entry_i.sum_y;
      result_o.min_x = CFG_W'(entry_i.min_x);
      result_o.max_x = entry_i.max_x;
      result_o.min_y = CFG_W'(entry_i.min_y);
      result_o.max_y = entry_i.max_y;
    end else begin
      result_o.area  = '0;
      result_o.sum_x = '0;
      result_o.sum_y = '0;
      result_o.min_x = image_width_i;
      result_o.max_x = '0;
      result_o.min_y = image_height_i;
      result_o.max_y = '0;
    end

    ctl_o = '0;
    case (kind_i)
      KIND_PIXEL: begin
        ctl_o.mem_we   = label_ok_i;
        ctl_o.set_used = label_ok_i;
      end
      KIND_QUERY: ctl_o.res_vld   = 1'b1;
      KIND_CLEAR: ctl_o.clear_all = 1'b1;
      default:    ctl_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/label_region_stats_unit.sv
// ----------------------------------------------------------------------------
// label_region_stats_unit
// Per-label area, coordinate sums and bounding box over a labeled image.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start_i while busy_o is low; busy_o stays low, so one
//   item is taken every clock. kind_i selects a pixel update, a query of one
//   label, or a clear of all labels. Label 0 is background.
//   A query answers from a register after the merge stage: valid_o pulses for one
//   cycle with area_o, sum_x_o, sum_y_o and the box. There is no back
//   pressure; the receiver must take the item in that cycle.
//   Pixel and clear items give no result.
//   Statistics live in a 256-entry RAM read as an item is taken and written
//   back by the merge stage; a label hit by two items in a row is served from
//   a bypass register. The per-label used bits are flops, so clear and reset
//   empty every label without a RAM sweep.
//   Reset sets image_width and image_height to 4096 and empties all labels.
//   cfg_we_i writes cfg_data_i to register cfg_idx_i (0 width, 1 height);
//   write it only while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module label_region_stats_unit
  import lrs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [COORD_BITS-1:0] pos_x_i,
  input  wire logic [COORD_BITS-1:0] pos_y_i,
  input  wire logic [LABEL_BITS-1:0] label_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  output logic                       valid_o,
  output logic [AREA_W-1:0]          area_o,
  output logic [SUM_W-1:0]           sum_x_o,
  output logic [SUM_W-1:0]           sum_y_o,
  output logic [CFG_W-1:0]           min_x_o,
  output logic [COORD_BITS-1:0]      max_x_o,
  output logic [CFG_W-1:0]           min_y_o,
  output logic [COORD_BITS-1:0]      max_y_o
);

  logic                  accept;
  logic                  s2_vld_q;
  logic [1:0]            s2_kind_q;
  logic [COORD_BITS-1:0] s2_x_q;
  logic [COORD_BITS-1:0] s2_y_q;
  logic [LABEL_BITS-1:0] s2_label_q;
  logic [LABELS-1:0]     used_q;
  logic [CFG_W-1:0]      image_width_q;
  logic [CFG_W-1:0]      image_height_q;
  logic                  fwd_vld_q;
  logic [LABEL_BITS-1:0] fwd_label_q;
  lrs_entry_t            fwd_entry_q;
  logic [ENTRY_W-1:0]    rdata;
  lrs_entry_t            old_entry;
  lrs_entry_t            new_entry;
  lrs_ctl_t              ctl;
  lrs_ctl_t              ctl_g;
  lrs_result_t           result;
  logic                  label_ok;
  logic                  s2_used;
  logic                  valid_q;
  lrs_result_t           res_q;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign label_ok = (s2_label_q != '0);
  assign s2_used  = used_q[s2_label_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= CFG_W'(13'd4096);
      image_height_q <= CFG_W'(13'd4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH:  image_width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_kind_q  <= kind_i;
      s2_x_q     <= pos_x_i;
      s2_y_q     <= pos_y_i;
      s2_label_q <= label_i;
    end
  end

  lrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LABELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_g.mem_we),
    .waddr_i (s2_label_q),
    .wdata_i (new_entry),
    .re_i    (accept),
    .raddr_i (label_i),
    .rdata_o (rdata)
  );

  // bypass: the RAM returns stale data when the previous item wrote this label
  assign old_entry = (fwd_vld_q && (fwd_label_q == s2_label_q)) ? fwd_entry_q
                                                                : lrs_entry_t'(rdata);

  lrs_merge u_merge (
    .kind_i         (s2_kind_q),
    .pos_x_i        (s2_x_q),
    .pos_y_i        (s2_y_q),
    .label_ok_i     (label_ok),
    .used_i         (s2_used),
    .entry_i        (old_entry),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .entry_o        (new_entry),
    .ctl_o          (ctl),
    .result_o       (result)
  );

  assign ctl_g = s2_vld_q ? ctl : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      fwd_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (ctl_g.clear_all) begin
        used_q <= '0;
      end else if (ctl_g.set_used) begin
        used_q[s2_label_q] <= 1'b1;
      end
      fwd_vld_q <= ctl_g.mem_we;
      valid_q   <= ctl_g.res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_g.mem_we) begin
      fwd_label_q <= s2_label_q;
      fwd_entry_q <= new_entry;
    end
    if (ctl_g.res_vld) begin
      res_q <= result;
    end
  end

  assign valid_o = valid_q;
  assign area_o  = res_q.area;
  assign sum_x_o = res_q.sum_x;
  assign sum_y_o = res_q.sum_y;
  assign min_x_o = res_q.min_x;
  assign max_x_o = res_q.max_x;
  assign min_y_o = res_q.min_y;
  assign max_y_o = res_q.max_y;

`ifndef SYNTHESIS
  a_res_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(s2_vld_q && (s2_kind_q == KIND_QUERY)))
    else $error("result without a query");

  a_no_bg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_g.mem_we |-> (s2_label_q != '0))
    else $error("background label written");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_g.clear_all |=> (used_q == '0))
    else $error("labels not empty after clear");

  a_pixel_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_g.set_used |=> used_q[$past(s2_label_q)])
    else $error("label not marked after pixel");

  a_empty_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_g.res_vld && (result.area == '0)) |->
      ((result.min_x == image_width_q) && (result.max_x == '0)))
    else $error("empty label box wrong");
`endif

endmodule

`default_nettype wire
